@@ design/abc_pkg.sv @@
// ----------------------------------------------------------------------------
// abc_pkg
// Shared types and constants of the audio bit crusher.
// ----------------------------------------------------------------------------
package abc_pkg;

  // Default sample width; the core accepts 8 to 32.
  localparam int SAMPLE_WIDTH_DEFAULT = 16;

  // Bits mode never goes beyond this depth, so a level count fits LEVEL_W bits.
  localparam int DEPTH_LIMIT = 16;
  localparam int LEVEL_W     = DEPTH_LIMIT;

  localparam int CFG_DATA_W = 8;

  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [CFG_DATA_W-1:0] depth_t;

  typedef enum logic {
    CFG_MODE  = 1'b0,
    CFG_DEPTH = 1'b1
  } cfg_index_t;

  typedef enum logic {
    MODE_BITS  = 1'b0,
    MODE_VALUE = 1'b1
  } crush_mode_t;

  localparam crush_mode_t MODE_RESET  = MODE_BITS;
  localparam depth_t      DEPTH_RESET = 8'd8;
  // Level count that follows from the reset mode and depth.
  localparam level_t      LEVEL_RESET = 16'd255;

endpackage

@@ design/audio_bit_crusher_core.sv @@
// ----------------------------------------------------------------------------
// audio_bit_crusher_core
// Requantizes signed audio samples to a configurable number of levels.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while m_tready does not stall the output.
// Reset: synchronous; clears the pipeline and sets bits mode with depth 8.
// Stages: offset, multiply by the level count, then one quotient bit per stage.

module audio_bit_crusher_core #(
  parameter int SAMPLE_WIDTH = abc_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [abc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,  // [SAMPLE_WIDTH-1:0] sample_in
  // Output stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata   // [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int LW     = abc_pkg::LEVEL_W;
  localparam int PROD_W = SAMPLE_WIDTH + LW;
  localparam logic [SAMPLE_WIDTH-1:0] HALF = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  abc_pkg::crush_mode_t mode;
  abc_pkg::depth_t      depth;
  abc_pkg::level_t      level;
  abc_pkg::level_t      level_next;

  logic [4:0]  depth_eff;
  logic [LW:0] pow_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= abc_pkg::MODE_RESET;
      depth <= abc_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (abc_pkg::cfg_index_t'(cfg_index))
        abc_pkg::CFG_MODE:  mode  <= abc_pkg::crush_mode_t'(cfg_data[0]);
        abc_pkg::CFG_DEPTH: depth <= cfg_data;
        default: ;
      endcase
    end
  end

  // Depth zero counts as one level; bits mode saturates the depth.
  always_comb begin
    if (depth == '0) begin
      depth_eff = 5'd1;
    end else if (depth > abc_pkg::depth_t'(abc_pkg::DEPTH_LIMIT)) begin
      depth_eff = 5'(abc_pkg::DEPTH_LIMIT);
    end else begin
      depth_eff = depth[4:0];
    end
    pow_level = (LW+1)'(1) << depth_eff;
    pow_level = pow_level - (LW+1)'(1);
    if (mode == abc_pkg::MODE_VALUE) begin
      level_next = (depth == '0) ? abc_pkg::level_t'(1) : abc_pkg::level_t'(depth);
    end else begin
      level_next = pow_level[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= abc_pkg::LEVEL_RESET;
    end else begin
      level <= level_next;
    end
  end

  // Offset stage.
  logic                    v1;
  logic                    rdy1;
  logic [SAMPLE_WIDTH-1:0] u1;
  // Multiply stage.
  logic                    v2;
  logic                    rdy2;
  logic [PROD_W-1:0]       prod2;
  logic                    div_ready;

  assign rdy2     = ~v2 | div_ready;
  assign rdy1     = ~v1 | rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      u1 <= s_tdata[SAMPLE_WIDTH-1:0] ^ HALF;
    end
    if (rdy2 && v1) begin
      prod2 <= PROD_W'(u1) * PROD_W'(level);
    end
  end

  logic [SAMPLE_WIDTH-1:0] quo;

  abc_divider #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .level     (level),
    .in_valid  (v2),
    .in_ready  (div_ready),
    .in_q      (prod2[PROD_W-1:SAMPLE_WIDTH]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_quo   (quo)
  );

  assign m_tdata = DATA_W'(quo ^ HALF);

endmodule

@@ design/abc_divider.sv @@
// ----------------------------------------------------------------------------
// abc_divider
// Pipelined restoring divider: computes floor(q * 2^W / level) for q < level,
// one quotient bit per register stage, with a ready chain that fills bubbles.
// ----------------------------------------------------------------------------
module abc_divider #(
  parameter int SAMPLE_WIDTH = abc_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  abc_pkg::level_t         level,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  abc_pkg::level_t         in_q,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH-1:0] out_quo
);

  localparam int LW = abc_pkg::LEVEL_W;

  logic [LW-1:0]           rem [SAMPLE_WIDTH];
  logic [SAMPLE_WIDTH-1:0] quo [SAMPLE_WIDTH];
  logic                    vld [SAMPLE_WIDTH];
  logic                    rdy [SAMPLE_WIDTH+1];

  assign rdy[SAMPLE_WIDTH] = out_ready;

  genvar k;
  generate
    for (k = 0; k < SAMPLE_WIDTH; k++) begin : g_stage
      logic [LW-1:0]           rem_src;
      logic [SAMPLE_WIDTH-1:0] quo_src;
      logic                    vld_src;
      logic [LW+1:0]           diff;
      logic                    take;
      logic [LW-1:0]           rem_next;
      logic [SAMPLE_WIDTH-1:0] quo_next;

      if (k == 0) begin : g_first
        assign rem_src = in_q;
        assign quo_src = '0;
        assign vld_src = in_valid;
      end else begin : g_rest
        assign rem_src = rem[k-1];
        assign quo_src = quo[k-1];
        assign vld_src = vld[k-1];
      end

      // The remainder stays below level, so the doubled value fits LW+1 bits.
      always_comb begin
        diff     = {1'b0, rem_src, 1'b0} - {2'b00, level};
        take     = ~diff[LW+1];
        rem_next = take ? diff[LW-1:0] : {rem_src[LW-2:0], 1'b0};
        quo_next = {quo_src[SAMPLE_WIDTH-2:0], take};
      end

      assign rdy[k] = ~vld[k] | rdy[k+1];

      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= vld_src;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k] && vld_src) begin
          rem[k] <= rem_next;
          quo[k] <= quo_next;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld[SAMPLE_WIDTH-1];
  assign out_quo   = quo[SAMPLE_WIDTH-1];

endmodule

@@ bench/audio_bit_crusher_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_bit_crusher_core_tb
// Self-checking bench for the bit crusher core. A short table of edge cases
// comes first, then random samples under many mode and depth settings. Every
// request is predicted at acceptance and each result is checked in order.
// Both stream sides stall at random in changing proportions.
// ----------------------------------------------------------------------------
module audio_bit_crusher_core_tb;

  localparam int SW        = abc_pkg::SAMPLE_WIDTH_DEFAULT;
  localparam int DATA_W    = ((SW + 7) / 8) * 8;
  localparam int LATENCY   = SW + 1;
  localparam int RUN_LIMIT = 200000;

  typedef struct {
    logic [6:0]           mode_pad;
    abc_pkg::crush_mode_t mode;
    abc_pkg::depth_t      depth;
    logic [SW-1:0]        sample;
    bit                   typed;
    logic [SW-1:0]        want;
  } crush_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic                           cfg_index = abc_pkg::CFG_MODE;
  logic [abc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [DATA_W-1:0]              s_tdata = '0;  // [SW-1:0] sample_in
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [DATA_W-1:0]              m_tdata;       // [SW-1:0] sample_out

  abc_pkg::crush_mode_t set_mode = abc_pkg::MODE_RESET;
  abc_pkg::depth_t      set_depth = abc_pkg::DEPTH_RESET;
  logic [6:0]           set_pad = '0;
  logic [SW-1:0]        pending_crushed[$];
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  int                   send_idle_pct = 38;
  int                   recv_idle_pct = 62;

  crush_row_t edge_rows [22] = '{
    '{7'h00, abc_pkg::MODE_BITS,  8'd8,   16'h8000, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd8,   16'h7FFF, 1'b1, 16'h7EFE},
    '{7'h00, abc_pkg::MODE_BITS,  8'd8,   16'h0000, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd8,   16'hFFFF, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd8,   16'h5555, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd8,   16'hAAAA, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd1,   16'h7FFF, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd16,  16'h7FFF, 1'b1, 16'h7FFE},
    '{7'h00, abc_pkg::MODE_BITS,  8'd16,  16'h8000, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd16,  16'h0001, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd17,  16'h3039, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd255, 16'hCFC7, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd1,   16'h7FFF, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd2,   16'h0000, 1'b1, 16'h0000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd2,   16'hFFFF, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd3,   16'h03E8, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd255, 16'h7FFF, 1'b0, 16'h0000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd255, 16'h8000, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_VALUE, 8'd0,   16'h7FFF, 1'b1, 16'h8000},
    '{7'h00, abc_pkg::MODE_BITS,  8'd0,   16'h0000, 1'b1, 16'h8000},
    '{7'h7F, abc_pkg::MODE_VALUE, 8'd5,   16'h4000, 1'b0, 16'h0000},
    '{7'h55, abc_pkg::MODE_BITS,  8'd4,   16'hC000, 1'b0, 16'h0000}
  };

  audio_bit_crusher_core #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [SW-1:0] crushed_sample(input logic [SW-1:0] x);
    logic [63:0] levels;
    logic [63:0] u;
    logic [63:0] q;
    logic [63:0] r;
    int unsigned d;
    d = (set_depth == 0) ? 1 : 32'(set_depth);
    if (set_mode == abc_pkg::MODE_VALUE) begin
      levels = 64'(d);
    end else begin
      if (d > abc_pkg::DEPTH_LIMIT) d = abc_pkg::DEPTH_LIMIT;
      levels = (64'd1 << d) - 64'd1;
    end
    u = 64'(x);
    u[SW-1] = ~u[SW-1];
    q = (u * levels) >> SW;
    r = (q << SW) / levels;
    r[SW-1] = ~r[SW-1];
    return r[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(SW-1){1'b0}}};
      1: return {1'b0, {(SW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 40) $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic cfg_write(input abc_pkg::cfg_index_t idx,
                           input logic [abc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle_pipeline();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_crushed.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [6:0] pad, input abc_pkg::crush_mode_t mode,
                                input abc_pkg::depth_t depth);
    settle_pipeline();
    cfg_write(abc_pkg::CFG_MODE, {pad, mode});
    cfg_write(abc_pkg::CFG_DEPTH, depth);
    set_pad   = pad;
    set_mode  = mode;
    set_depth = depth;
  endtask

  task automatic send_sample(input logic [SW-1:0] x, input bit typed,
                             input logic [SW-1:0] want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_W'(x);
    do @(posedge clk); while (!s_tready);
    pending_crushed.push_back(typed ? want : crushed_sample(x));
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_crushed.size() == 0) begin
        report_mismatch($sformatf("unexpected result sample_out=%h", m_tdata[SW-1:0]));
      end else if (m_tdata[SW-1:0] !== pending_crushed[0]) begin
        report_mismatch($sformatf("sample_out=%h, predicted %h",
                                  m_tdata[SW-1:0], pending_crushed[0]));
        void'(pending_crushed.pop_front());
      end else begin
        void'(pending_crushed.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("audio_bit_crusher_core regression: fail");
      $finish;
    end
  end

  initial begin
    crush_row_t      row;
    logic [6:0]      pad;
    abc_pkg::depth_t depth;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (edge_rows[i]) begin
      row = edge_rows[i];
      if (row.mode != set_mode || row.depth != set_depth || row.mode_pad != set_pad)
        apply_settings(row.mode_pad, row.mode, row.depth);
      send_sample(row.sample, row.typed, row.want);
    end

    for (int ph = 0; ph < 15; ph++) begin
      if (ph == 5) begin
        send_idle_pct = 62;
        recv_idle_pct = 38;
      end else if (ph == 10) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pad = 7'($urandom);
      case ($urandom_range(0, 5))
        0: depth = 8'd1;
        1: depth = 8'd255;
        2: depth = 8'($urandom_range(14, 18));
        default: depth = 8'($urandom_range(0, 255));
      endcase
      apply_settings(pad, ph[0] ? abc_pkg::MODE_VALUE : abc_pkg::MODE_BITS, depth);
      repeat (50) send_sample(pick_sample(), 1'b0, '0);
    end

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("audio_bit_crusher_core regression: pass");
    end else begin
      $display("audio_bit_crusher_core regression: fail");
    end
    $finish;
  end

endmodule
